// ===== rtl/bht_pkg.sv =====
// Package for the bucketed hash table: action and status codes, queue entry type.
// No dependencies.
`timescale 1ns / 1ps
package bht_pkg;
	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_DUP  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	localparam int KEY_BITS = 256;
	localparam int OUT_HANDLE_BITS = 16;

	typedef struct packed {
		action_t             act;
		logic [KEY_BITS-1:0] key;
		logic [15:0]         handle;
	} req_t;
endpackage

// ===== rtl/bucketed_hash_table.sv =====
// Top level of the bucketed hash table: front queue plus back execution unit.
// Depends on bht_pkg, bht_front and bht_back.
//
// Each item looks up, inserts or removes a 256-bit key in bucket key_word0 mod
// BUCKET_COUNT, which holds WAYS slots; BUCKET_COUNT must be a power of two, so
// the bucket is the low bits of key_word0. In the back unit each item is first
// read from the bucket in S_READ, then in S_EXEC all ways are compared at once
// and the bucket is written back once the output register is free or taken; the
// next item is not read until that is done. The front holds up to two items in
// a queue, and a finished result waits in an output register while the next
// item is read. The table is empty after reset; no clearing pass is needed.
`timescale 1ns / 1ps
module bucketed_hash_table #(
	parameter int BUCKET_COUNT = 64,
	parameter int WAYS         = 4,
	parameter int HANDLE_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [63:0] key_word0,
	input  logic [63:0] key_word1,
	input  logic [63:0] key_word2,
	input  logic [63:0] key_word3,
	input  logic [15:0] handle_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] handle_out
);
	import bht_pkg::*;

	req_t in_req, q_req;
	logic q_valid, q_pop;

	// Pack the item; word 0 is the low end so the bucket is its low bits.
	assign in_req.act    = action_t'(action);
	assign in_req.key    = {key_word3, key_word2, key_word1, key_word0};
	assign in_req.handle = handle_in;

	bht_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_req,
		.q_valid, .q_pop, .q_req
	);

	bht_back #(
		.BUCKET_COUNT(BUCKET_COUNT), .WAYS(WAYS), .HANDLE_BITS(HANDLE_BITS)
	) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_req,
		.out_valid, .out_ready, .status, .handle_out
	);
endmodule

// ===== rtl/bht_front.sv =====
// Front part: accepts items and pushes them into a two-entry queue.
// Depends on bht_pkg.
`timescale 1ns / 1ps
module bht_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bht_pkg::req_t in_req,
	output logic          q_valid,
	input  logic          q_pop,
	output bht_pkg::req_t q_req
);
	import bht_pkg::*;

	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

// ===== rtl/bht_back.sv =====
// Back part: bucket read, parallel way compare, write-back and result register.
// Depends on bht_pkg.
`timescale 1ns / 1ps
module bht_back #(
	parameter int BUCKET_COUNT = 64,
	parameter int WAYS         = 4,
	parameter int HANDLE_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_pop,
	input  bht_pkg::req_t q_req,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    status,
	output logic [15:0]   handle_out
);
	import bht_pkg::*;

	localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int HB = (HANDLE_BITS < OUT_HANDLE_BITS) ? HANDLE_BITS : OUT_HANDLE_BITS;

	typedef enum logic [1:0] {S_READ = 2'b01, S_EXEC = 2'b10} state_t;

	logic [KEY_BITS-1:0] key_mem [BUCKET_COUNT][WAYS];
	logic [HB-1:0]       hnd_mem [BUCKET_COUNT][WAYS];
	logic [WAYS-1:0]     vld_q   [BUCKET_COUNT];

	state_t              state_q;
	logic [KEY_BITS-1:0] rd_key_s1 [WAYS];
	logic [HB-1:0]       rd_hnd_s1 [WAYS];
	logic [WAYS-1:0]     rd_vld_s1;
	logic [BW-1:0]       bkt;
	logic [WAYS-1:0]     hit_vec;
	logic                hit, has_free;
	logic [WW-1:0]       hit_way, free_way;
	logic                res_free;
	logic                do_ins, do_rem;
	status_t             st;
	logic [15:0]         hout;

	// BUCKET_COUNT is a power of two, so the bucket is the low bits of word 0.
	always_comb begin
		bkt = q_req.key[BW-1:0];
	end

	always_comb begin
		hit = 1'b0; has_free = 1'b0; hit_way = '0; free_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = rd_vld_s1[w] && (rd_key_s1[w] == q_req.key);
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit = 1'b1; hit_way = WW'(w);
			end
			if (!rd_vld_s1[w]) begin
				has_free = 1'b1; free_way = WW'(w);
			end
		end
	end

	always_comb begin
		st = ST_MISS; hout = '0; do_ins = 1'b0; do_rem = 1'b0;
		unique case (q_req.act)
			ACT_LOOKUP: if (hit) begin
				st = ST_OK; hout = 16'(rd_hnd_s1[hit_way]);
			end
			ACT_INSERT: begin
				if (hit) st = ST_DUP;
				else if (!has_free) st = ST_FULL;
				else begin
					st = ST_OK; do_ins = 1'b1;
				end
			end
			ACT_REMOVE: if (hit) begin
				st = ST_OK; do_rem = 1'b1;
			end
			default: st = ST_MISS;
		endcase
	end

	assign res_free = !out_valid || out_ready;
	assign q_pop    = (state_q == S_EXEC) && res_free;

	// Bucket read and write-back.
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			for (int w = 0; w < WAYS; w++) begin
				rd_key_s1[w] <= key_mem[bkt][w];
				rd_hnd_s1[w] <= hnd_mem[bkt][w];
			end
		end
		if (q_pop && do_ins) begin
			key_mem[bkt][free_way] <= q_req.key;
			hnd_mem[bkt][free_way] <= q_req.handle[HB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_READ;
			out_valid <= 1'b0;
			rd_vld_s1 <= '0;
			for (int b = 0; b < BUCKET_COUNT; b++) vld_q[b] <= '0;
		end else begin
			// Raise on a new result, drop once the held one is taken.
			if (q_pop) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_READ: if (q_valid) begin
					rd_vld_s1 <= vld_q[bkt];
					state_q   <= S_EXEC;
				end
				S_EXEC: if (res_free) begin
					if (do_ins) vld_q[bkt][free_way] <= 1'b1;
					if (do_rem) vld_q[bkt][hit_way] <= 1'b0;
					state_q <= S_READ;
				end
				default: state_q <= S_READ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			status     <= st;
			handle_out <= hout;
		end
	end
endmodule

// ===== rtl/bht_checker.sv =====
// Port-level checker for the bucketed hash table, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
module bht_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [15:0] handle_out
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped while stalled");
	a_handle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(handle_out))
		else $error("handle changed while stalled");
	a_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 2'd0 |-> handle_out == 16'd0)
		else $error("handle nonzero on failure");
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");
endmodule

bind bucketed_hash_table bht_checker u_chk (.*);
